@@ hw/rtl/ppcl_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// ppcl_pkg
// Shared types and constants of the parallel port copier link engine.
// ----------------------------------------------------------------------------
package ppcl_pkg;

	// Request kinds
	localparam logic [2:0] REQ_FRAME  = 3'd0;
	localparam logic [2:0] REQ_DATA   = 3'd1;
	localparam logic [2:0] REQ_SUM    = 3'd2;
	localparam logic [2:0] REQ_RX     = 3'd3;
	localparam logic [2:0] REQ_RX_CHK = 3'd4;
	localparam logic [2:0] REQ_CLR    = 3'd5;

	// Configuration register indexes
	localparam logic CFG_POLL_LIMIT = 1'b0;
	localparam logic CFG_RX_MIN     = 1'b1;

	// Frame constants
	localparam logic [7:0] SYNC_0   = 8'hD5;
	localparam logic [7:0] SYNC_1   = 8'hAA;
	localparam logic [7:0] SYNC_2   = 8'h96;
	localparam logic [7:0] SUM_SEED = 8'h81;
	localparam logic [3:0] FRAME_LAST_IDX = 4'd8;

	// Frame byte positions
	localparam logic [3:0] FB_SYNC_0 = 4'd0;
	localparam logic [3:0] FB_SYNC_1 = 4'd1;
	localparam logic [3:0] FB_SYNC_2 = 4'd2;
	localparam logic [3:0] FB_CODE   = 4'd3;
	localparam logic [3:0] FB_ADDR_L = 4'd4;
	localparam logic [3:0] FB_ADDR_H = 4'd5;
	localparam logic [3:0] FB_LEN_L  = 4'd6;
	localparam logic [3:0] FB_LEN_H  = 4'd7;

	// Configuration reset values
	localparam logic [15:0] POLL_LIMIT_RST = 16'd65534;
	localparam logic [7:0]  RX_MIN_RST     = 8'd3;

	typedef enum logic [4:0] {
		PH_IDLE      = 5'b00001,
		PH_SEND_PRE  = 5'b00010,
		PH_SEND_POST = 5'b00100,
		PH_RX_LO     = 5'b01000,
		PH_RX_HI     = 5'b10000
	} phase_t;

	// One tick presented on the input channel
	typedef struct packed {
		logic        req_valid;
		logic [2:0]  req_type;
		logic [7:0]  cmd_code;
		logic [15:0] address;
		logic [15:0] length;
		logic [7:0]  data_byte;
		logic [7:0]  status_pins;
	} item_t;

	// Request held while a transfer runs
	typedef struct packed {
		logic [2:0]  kind;
		logic [7:0]  code;
		logic [15:0] addr;
		logic [15:0] len;
		logic [7:0]  data;
	} req_t;

	typedef struct packed {
		phase_t      phase;
		logic [3:0]  frame_idx;
		logic [15:0] poll_cnt;
		logic [7:0]  cksum;
		logic        strobe;
		logic        led;
		logic        timed_out;
		logic [7:0]  rx_asm;
		logic [7:0]  data_reg;
	} state_t;

	typedef struct packed {
		logic [7:0] data_pins;
		logic       strobe_level;
		logic       led_level;
		logic       ready_res;
		logic       done_res;
		logic [7:0] rx_byte;
		logic       rx_valid;
		logic       checksum_error;
		logic       timeout_flag;
	} result_t;

endpackage
`default_nettype wire

@@ hw/rtl/ppcl_step.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// ppcl_step
// Next-state and result logic for one tick: one poll of busy at most, plus
// every action that follows without waiting.
// ----------------------------------------------------------------------------
module ppcl_step (
	input  wire ppcl_pkg::state_t st,
	input  wire ppcl_pkg::req_t   held,
	input  wire ppcl_pkg::item_t  it,
	input  wire logic [15:0]      poll_limit,
	input  wire logic [7:0]       rx_min_polls,
	output ppcl_pkg::state_t      st_nx,
	output ppcl_pkg::req_t        held_nx,
	output logic                  held_we,
	output ppcl_pkg::result_t     res
);

	function automatic logic [7:0] frame_byte(input logic [3:0] idx,
			input ppcl_pkg::req_t r, input logic [7:0] sum, input logic [7:0] chk);
		logic [7:0] b;
		b = chk;
		if (r.kind == ppcl_pkg::REQ_DATA) begin
			b = r.data;
		end else if (r.kind == ppcl_pkg::REQ_SUM) begin
			b = sum;
		end else begin
			case (idx)
				ppcl_pkg::FB_SYNC_0: b = ppcl_pkg::SYNC_0;
				ppcl_pkg::FB_SYNC_1: b = ppcl_pkg::SYNC_1;
				ppcl_pkg::FB_SYNC_2: b = ppcl_pkg::SYNC_2;
				ppcl_pkg::FB_CODE:   b = r.code;
				ppcl_pkg::FB_ADDR_L: b = r.addr[7:0];
				ppcl_pkg::FB_ADDR_H: b = r.addr[15:8];
				ppcl_pkg::FB_LEN_L:  b = r.len[7:0];
				ppcl_pkg::FB_LEN_H:  b = r.len[15:8];
				default:             b = chk;
			endcase
		end
		return b;
	endfunction

	logic             start_req;
	logic             clr_req;
	ppcl_pkg::req_t   rq;
	ppcl_pkg::phase_t ph;
	logic [3:0]       fi;
	logic [15:0]      pc;
	logic [15:0]      pc_inc;
	logic [15:0]      min_polls;
	logic [7:0]       cs;
	logic             to;
	logic             is_rx;
	logic             want_busy;
	logic             busy;
	logic             keep_wait;
	logic             active;
	logic             fire;
	logic             new_to;
	logic             finish;
	logic             toggle;
	logic [7:0]       chk;
	logic [3:0]       nib;
	logic [7:0]       rx_b;
	logic             rxv;
	logic             done;
	logic             cerr;

	always_comb begin
		// take a new request only while idle
		start_req = st.phase == ppcl_pkg::PH_IDLE && it.req_valid &&
			it.req_type <= ppcl_pkg::REQ_RX_CHK;
		clr_req = st.phase == ppcl_pkg::PH_IDLE && it.req_valid &&
			it.req_type == ppcl_pkg::REQ_CLR;

		held_we         = start_req;
		held_nx.kind    = it.req_type;
		held_nx.code    = it.cmd_code;
		held_nx.addr    = it.address;
		held_nx.len     = it.length;
		held_nx.data    = it.data_byte;
		rq = start_req ? held_nx : held;

		// entry state of this tick
		if (start_req) begin
			ph = (it.req_type <= ppcl_pkg::REQ_SUM) ? ppcl_pkg::PH_SEND_PRE
				: ppcl_pkg::PH_RX_LO;
		end else begin
			ph = st.phase;
		end
		fi = start_req ? 4'd0 : st.frame_idx;
		pc = start_req ? 16'd0 : st.poll_cnt;
		cs = (start_req && it.req_type == ppcl_pkg::REQ_FRAME) ? ppcl_pkg::SUM_SEED
			: st.cksum;
		to = clr_req ? 1'b0 : st.timed_out;

		// single poll of the busy line
		is_rx     = ph == ppcl_pkg::PH_RX_LO || ph == ppcl_pkg::PH_RX_HI;
		want_busy = !is_rx;
		busy      = !it.status_pins[7];
		pc_inc    = pc + 16'd1;
		min_polls = is_rx ? {8'd0, rx_min_polls} : 16'd0;
		keep_wait = pc_inc < min_polls || (busy != want_busy && pc_inc < poll_limit);
		active    = ph != ppcl_pkg::PH_IDLE;
		fire      = active && (to || !keep_wait);
		new_to    = active && !to && !keep_wait && busy != want_busy;
		// once timed out, every later wait passes: run to completion
		finish    = to || new_to;

		chk = ppcl_pkg::SUM_SEED ^ rq.code ^ rq.addr[7:0] ^ rq.addr[15:8] ^
			rq.len[7:0] ^ rq.len[15:8];
		nib = it.status_pins[6:3];

		st_nx           = st;
		st_nx.phase     = ph;
		st_nx.frame_idx = fi;
		st_nx.cksum     = cs;
		st_nx.timed_out = to | new_to;
		if (active && !to) begin
			st_nx.poll_cnt = keep_wait ? pc_inc : 16'd0;
		end else begin
			st_nx.poll_cnt = pc;
		end

		toggle = 1'b0;
		rx_b   = 8'd0;
		rxv    = 1'b0;
		cerr   = 1'b0;
		done   = clr_req;

		if (fire) begin
			case (ph)
				ppcl_pkg::PH_SEND_PRE: begin
					if (finish) begin
						st_nx.phase     = ppcl_pkg::PH_IDLE;
						st_nx.frame_idx = 4'd0;
						done = 1'b1;
						case (rq.kind)
							ppcl_pkg::REQ_FRAME: begin
								st_nx.data_reg = chk;
								toggle = !fi[0];
							end
							ppcl_pkg::REQ_DATA: begin
								st_nx.data_reg = rq.data;
								st_nx.cksum    = cs ^ rq.data;
								toggle = 1'b1;
							end
							default: begin
								st_nx.data_reg = cs;
								toggle = 1'b1;
							end
						endcase
					end else begin
						st_nx.data_reg = frame_byte(fi, rq, cs, chk);
						st_nx.phase    = ppcl_pkg::PH_SEND_POST;
						toggle = 1'b1;
					end
				end
				ppcl_pkg::PH_SEND_POST: begin
					if (rq.kind == ppcl_pkg::REQ_FRAME && fi < ppcl_pkg::FRAME_LAST_IDX) begin
						if (finish) begin
							st_nx.data_reg  = chk;
							st_nx.phase     = ppcl_pkg::PH_IDLE;
							st_nx.frame_idx = 4'd0;
							toggle = fi[0];
							done   = 1'b1;
						end else begin
							st_nx.frame_idx = fi + 4'd1;
							st_nx.phase     = ppcl_pkg::PH_SEND_PRE;
						end
					end else begin
						if (rq.kind == ppcl_pkg::REQ_DATA) begin
							st_nx.cksum = cs ^ rq.data;
						end
						st_nx.phase     = ppcl_pkg::PH_IDLE;
						st_nx.frame_idx = 4'd0;
						done = 1'b1;
					end
				end
				ppcl_pkg::PH_RX_LO: begin
					if (finish) begin
						// both nibbles come from the same sample; strobe keeps its old level, as two toggles would leave it
						rx_b         = {nib, nib};
						st_nx.rx_asm = rx_b;
						st_nx.phase  = ppcl_pkg::PH_IDLE;
						rxv  = 1'b1;
						done = 1'b1;
						if (rq.kind == ppcl_pkg::REQ_RX) begin
							st_nx.cksum = cs ^ rx_b;
						end else begin
							cerr = rx_b != cs;
						end
					end else begin
						st_nx.rx_asm = {4'd0, nib};
						st_nx.phase  = ppcl_pkg::PH_RX_HI;
						toggle = 1'b1;
					end
				end
				ppcl_pkg::PH_RX_HI: begin
					rx_b         = st.rx_asm | {nib, 4'd0};
					st_nx.rx_asm = rx_b;
					st_nx.phase  = ppcl_pkg::PH_IDLE;
					toggle = 1'b1;
					rxv    = 1'b1;
					done   = 1'b1;
					if (rq.kind == ppcl_pkg::REQ_RX) begin
						st_nx.cksum = cs ^ rx_b;
					end else begin
						cerr = rx_b != cs;
					end
				end
				default: begin
					st_nx.phase = ppcl_pkg::PH_IDLE;
				end
			endcase
		end

		st_nx.strobe = st.strobe ^ toggle;
		st_nx.led    = st.led ^ toggle;

		// result of this tick
		res.data_pins      = st_nx.data_reg;
		res.strobe_level   = st_nx.strobe;
		res.led_level      = st_nx.led;
		res.ready_res      = st_nx.phase == ppcl_pkg::PH_IDLE;
		res.done_res       = done;
		res.rx_byte        = rx_b;
		res.rx_valid       = rxv;
		res.checksum_error = cerr;
		res.timeout_flag   = st_nx.timed_out;
	end

endmodule
`default_nettype wire

@@ hw/rtl/parallel_port_copier_link.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// parallel_port_copier_link
// Host-side parallel port link engine: command frames, data bytes and
// checksums sent with busy handshake, bytes received in nibble mode.
// ----------------------------------------------------------------------------
//  channel  | handshake            | payload
//  ---------+----------------------+---------------------------------------
//  in       | in_valid / in_stall  | req_valid .. status_pins (one tick)
//  out      | out_valid / out_stall| data_pins .. timeout_flag
//  cfg      | cfg_we               | cfg_index, cfg_wdata
//
//  One tick transfers per cycle while in_stall is low; its result reaches the
//  output register through the input register, then the result register.
//  Link state advances only when the result register can take a new result.
//  arst_n resets the link state, the checksum to 0x81, and loads poll_limit 65534, rx_min_polls 3.
//  A stalled output holds its result; in_stall rises when both stages are full and the output is stalled.
// ----------------------------------------------------------------------------
module parallel_port_copier_link (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [0:0]  cfg_index,
	input  wire logic [15:0] cfg_wdata,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic        req_valid,
	input  wire logic [2:0]  req_type,
	input  wire logic [7:0]  cmd_code,
	input  wire logic [15:0] address,
	input  wire logic [15:0] length,
	input  wire logic [7:0]  data_byte,
	input  wire logic [7:0]  status_pins,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [7:0]       data_pins,
	output logic             strobe_level,
	output logic             led_level,
	output logic             ready_res,
	output logic             done_res,
	output logic [7:0]       rx_byte,
	output logic             rx_valid,
	output logic             checksum_error,
	output logic             timeout_flag
);

	logic              valid_s1;
	ppcl_pkg::item_t   item_s1;
	logic              out_valid_q;
	ppcl_pkg::result_t res_q;
	ppcl_pkg::state_t  state_q;
	ppcl_pkg::req_t    held_q;
	logic [15:0]       poll_limit_q;
	logic [7:0]        rx_min_q;

	ppcl_pkg::state_t  st_nx;
	ppcl_pkg::req_t    held_nx;
	logic              held_we;
	ppcl_pkg::result_t res;
	logic              advance;
	logic              take_in;
	logic              step;

	assign advance  = !out_valid_q || !out_stall;
	assign in_stall = valid_s1 && !advance;
	assign take_in  = in_valid && !in_stall;
	assign step     = valid_s1 && advance;

	ppcl_step u_step (
		.st           (state_q),
		.held         (held_q),
		.it           (item_s1),
		.poll_limit   (poll_limit_q),
		.rx_min_polls (rx_min_q),
		.st_nx        (st_nx),
		.held_nx      (held_nx),
		.held_we      (held_we),
		.res          (res)
	);

	// write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			poll_limit_q <= ppcl_pkg::POLL_LIMIT_RST;
			rx_min_q     <= ppcl_pkg::RX_MIN_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				ppcl_pkg::CFG_POLL_LIMIT: poll_limit_q <= cfg_wdata;
				ppcl_pkg::CFG_RX_MIN:     rx_min_q     <= cfg_wdata[7:0];
				default: ;
			endcase
		end
	end

	// capture the incoming tick
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take_in) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take_in) begin
			item_s1 <= '{req_valid, req_type, cmd_code, address, length,
				data_byte, status_pins};
		end
	end

	// advance link state and hold the result until its transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q       <= 1'b0;
			state_q.phase     <= ppcl_pkg::PH_IDLE;
			state_q.frame_idx <= 4'd0;
			state_q.poll_cnt  <= 16'd0;
			state_q.cksum     <= ppcl_pkg::SUM_SEED;
			state_q.strobe    <= 1'b0;
			state_q.led       <= 1'b0;
			state_q.timed_out <= 1'b0;
			state_q.rx_asm    <= 8'd0;
			state_q.data_reg  <= 8'd0;
		end else if (step) begin
			out_valid_q <= 1'b1;
			state_q     <= st_nx;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			res_q <= res;
		end
		if (step && held_we) begin
			held_q <= held_nx;
		end
	end

	assign out_valid      = out_valid_q;
	assign data_pins      = res_q.data_pins;
	assign strobe_level   = res_q.strobe_level;
	assign led_level      = res_q.led_level;
	assign ready_res      = res_q.ready_res;
	assign done_res       = res_q.done_res;
	assign rx_byte        = res_q.rx_byte;
	assign rx_valid       = res_q.rx_valid;
	assign checksum_error = res_q.checksum_error;
	assign timeout_flag   = res_q.timeout_flag;

endmodule
`default_nettype wire

@@ hw/rtl/ppcl_checker.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// ppcl_port_checks
// Port-level checks of the link engine result channel.
// ----------------------------------------------------------------------------
module ppcl_port_checks (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       out_valid,
	input wire logic       out_stall,
	input wire logic [7:0] data_pins,
	input wire logic       strobe_level,
	input wire logic       led_level,
	input wire logic       ready_res,
	input wire logic       done_res,
	input wire logic       rx_valid,
	input wire logic       checksum_error
);

	// a stalled result holds until its transfer
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(data_pins) && $stable(done_res))
		else $error("stalled result changed");

	// strobe and LED always toggle together
	a_led: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> strobe_level == led_level)
		else $error("strobe and LED diverged");

	// a received byte always completes its request
	a_rx_done: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && rx_valid |-> done_res)
		else $error("receive without completion");

	// checksum error only with a received byte
	a_cerr: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && checksum_error |-> rx_valid)
		else $error("checksum error without receive");

	// completion leaves the engine idle
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && done_res |-> ready_res)
		else $error("completion while still busy");

endmodule

bind parallel_port_copier_link ppcl_port_checks u_ppcl_port_checks (
	.clk            (clk),
	.arst_n         (arst_n),
	.out_valid      (out_valid),
	.out_stall      (out_stall),
	.data_pins      (data_pins),
	.strobe_level   (strobe_level),
	.led_level      (led_level),
	.ready_res      (ready_res),
	.done_res       (done_res),
	.rx_valid       (rx_valid),
	.checksum_error (checksum_error)
);
`default_nettype wire

@@ dv/ppcl_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppcl_checker
// Watches the tick and result channels of the parallel port link engine.
// Every tick transfer runs through a cycle-level model of the link and
// queues the result it should produce; every result transfer is compared
// field by field with the oldest queued one. Register writes update the
// model's copy of the configuration.
// ----------------------------------------------------------------------------
module ppcl_checker
	import ppcl_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [0:0]  cfg_index,
	input  wire logic [15:0] cfg_wdata,
	input  wire logic        in_valid,
	input  wire logic        in_stall,
	input  wire logic        req_valid,
	input  wire logic [2:0]  req_type,
	input  wire logic [7:0]  cmd_code,
	input  wire logic [15:0] address,
	input  wire logic [15:0] length,
	input  wire logic [7:0]  data_byte,
	input  wire logic [7:0]  status_pins,
	input  wire logic        out_valid,
	input  wire logic        out_stall,
	input  wire logic [7:0]  data_pins,
	input  wire logic        strobe_level,
	input  wire logic        led_level,
	input  wire logic        ready_res,
	input  wire logic        done_res,
	input  wire logic [7:0]  rx_byte,
	input  wire logic        rx_valid,
	input  wire logic        checksum_error,
	input  wire logic        timeout_flag,
	output int               errors,
	output int               due_count
);

	// Link model state
	logic [15:0] lim;
	logic [7:0]  rx_min;
	phase_t      link_phase;
	logic [3:0]  frame_idx;
	logic [15:0] poll_cnt;
	logic [7:0]  run_sum;
	logic        strobe;
	logic        led;
	logic        timed_out;
	logic [7:0]  rx_asm;
	logic [7:0]  data_q;
	req_t        held;
	logic        polled_now;

	result_t     link_outputs_due[$];
	result_t     want;
	item_t       tick_now;

	assign tick_now = {req_valid, req_type, cmd_code, address, length, data_byte, status_pins};

	// Load reset values into the model
	task automatic clear_link();
		lim        = POLL_LIMIT_RST;
		rx_min     = RX_MIN_RST;
		link_phase = PH_IDLE;
		frame_idx  = '0;
		poll_cnt   = '0;
		run_sum    = SUM_SEED;
		strobe     = 1'b0;
		led        = 1'b0;
		timed_out  = 1'b0;
		rx_asm     = '0;
		data_q     = '0;
		held       = '0;
		link_outputs_due.delete();
	endtask

	// One poll of the busy line per tick; sticky timeout skips the wait
	function automatic logic busy_wait(input logic wanted, input logic [7:0] min_polls,
			input logic [7:0] st);
		logic busy;
		if (timed_out)
			return 1'b1;
		if (polled_now)
			return 1'b0;
		polled_now = 1'b1;
		poll_cnt = poll_cnt + 16'd1;
		busy = ~st[7];
		if (poll_cnt < {8'd0, min_polls} || (busy != wanted && poll_cnt < lim))
			return 1'b0;
		if (busy != wanted)
			timed_out = 1'b1;
		poll_cnt = '0;
		return 1'b1;
	endfunction

	function automatic logic [7:0] next_tx_byte();
		if (held.kind == REQ_DATA)
			return held.data;
		if (held.kind == REQ_SUM)
			return run_sum;
		case (frame_idx)
			FB_SYNC_0: return SYNC_0;
			FB_SYNC_1: return SYNC_1;
			FB_SYNC_2: return SYNC_2;
			FB_CODE:   return held.code;
			FB_ADDR_L: return held.addr[7:0];
			FB_ADDR_H: return held.addr[15:8];
			FB_LEN_L:  return held.len[7:0];
			FB_LEN_H:  return held.len[15:8];
			default:   return SUM_SEED ^ held.code ^ held.addr[7:0] ^ held.addr[15:8]
				^ held.len[7:0] ^ held.len[15:8];
		endcase
	endfunction

	// Advance the link by one tick and form the result it produces
	function automatic result_t step_link(input item_t t);
		result_t r;
		logic    running;
		logic    done;
		logic    rxv;
		logic    cerr;
		logic [7:0] rxb;
		polled_now = 1'b0;
		running = 1'b1;
		done = 1'b0;
		rxv = 1'b0;
		cerr = 1'b0;
		rxb = '0;
		// accept a request only when idle
		if (link_phase == PH_IDLE && t.req_valid) begin
			if (t.req_type == REQ_CLR) begin
				timed_out = 1'b0;
				done = 1'b1;
			end else if (t.req_type <= REQ_RX_CHK) begin
				held.kind = t.req_type;
				held.code = t.cmd_code;
				held.addr = t.address;
				held.len  = t.length;
				held.data = t.data_byte;
				frame_idx = '0;
				poll_cnt = '0;
				if (t.req_type == REQ_FRAME)
					run_sum = SUM_SEED;
				if (t.req_type <= REQ_SUM)
					link_phase = PH_SEND_PRE;
				else
					link_phase = PH_RX_LO;
			end
		end
		// run until a wait needs another tick or the request finishes
		while (running && link_phase != PH_IDLE) begin
			case (link_phase)
				PH_SEND_PRE: begin
					if (!busy_wait(1'b1, 8'd0, t.status_pins)) begin
						running = 1'b0;
					end else begin
						data_q = next_tx_byte();
						strobe = ~strobe;
						led = ~led;
						link_phase = PH_SEND_POST;
					end
				end
				PH_SEND_POST: begin
					if (!busy_wait(1'b1, 8'd0, t.status_pins)) begin
						running = 1'b0;
					end else if (held.kind == REQ_FRAME && frame_idx < FRAME_LAST_IDX) begin
						frame_idx = frame_idx + 4'd1;
						link_phase = PH_SEND_PRE;
					end else begin
						if (held.kind == REQ_DATA)
							run_sum = run_sum ^ held.data;
						frame_idx = '0;
						done = 1'b1;
						link_phase = PH_IDLE;
					end
				end
				PH_RX_LO: begin
					if (!busy_wait(1'b0, rx_min, t.status_pins)) begin
						running = 1'b0;
					end else begin
						rx_asm = {4'd0, t.status_pins[6:3]};
						strobe = ~strobe;
						led = ~led;
						link_phase = PH_RX_HI;
					end
				end
				PH_RX_HI: begin
					if (!busy_wait(1'b0, rx_min, t.status_pins)) begin
						running = 1'b0;
					end else begin
						rx_asm = rx_asm | {t.status_pins[6:3], 4'd0};
						strobe = ~strobe;
						led = ~led;
						rxb = rx_asm;
						rxv = 1'b1;
						if (held.kind == REQ_RX)
							run_sum = run_sum ^ rxb;
						else
							cerr = (rxb != run_sum);
						done = 1'b1;
						link_phase = PH_IDLE;
					end
				end
				default: begin
					link_phase = PH_IDLE;
				end
			endcase
		end
		r.data_pins      = data_q;
		r.strobe_level   = strobe;
		r.led_level      = led;
		r.ready_res      = (link_phase == PH_IDLE);
		r.done_res       = done;
		r.rx_byte        = rxb;
		r.rx_valid       = rxv;
		r.checksum_error = cerr;
		r.timeout_flag   = timed_out;
		return r;
	endfunction

	task automatic check_field(input string name, input logic [7:0] exp_v,
			input logic [7:0] got_v);
		if (exp_v !== got_v) begin
			$error("%s: expected %0h, got %0h", name, exp_v, got_v);
			errors++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_link();
			errors = 0;
			due_count = 0;
		end else begin
			// register writes land between ticks
			if (cfg_we) begin
				if (cfg_index == CFG_POLL_LIMIT)
					lim = cfg_wdata;
				else
					rx_min = cfg_wdata[7:0];
			end
			// predict each tick transfer
			if (in_valid && !in_stall)
				link_outputs_due.push_back(step_link(tick_now));
			// compare each result transfer against the oldest prediction
			if (out_valid && !out_stall) begin
				if (link_outputs_due.size() == 0) begin
					$error("result transfer with no tick outstanding");
					errors++;
				end else begin
					want = link_outputs_due.pop_front();
					check_field("data_pins", want.data_pins, data_pins);
					check_field("strobe_level", 8'(want.strobe_level), 8'(strobe_level));
					check_field("led_level", 8'(want.led_level), 8'(led_level));
					check_field("ready_res", 8'(want.ready_res), 8'(ready_res));
					check_field("done_res", 8'(want.done_res), 8'(done_res));
					check_field("rx_byte", want.rx_byte, rx_byte);
					check_field("rx_valid", 8'(want.rx_valid), 8'(rx_valid));
					check_field("checksum_error", 8'(want.checksum_error),
						8'(checksum_error));
					check_field("timeout_flag", 8'(want.timeout_flag), 8'(timeout_flag));
				end
			end
			due_count = link_outputs_due.size();
		end
	end

endmodule

@@ dv/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Stimulus for the parallel port link engine. Directed ticks cover command
// frames with extreme fields, data bytes, checksum send, nibble receive with
// and without checksum match, ignored request kinds, requests while busy,
// zero poll limit and sticky timeout with its clear. Random ticks then run
// under several poll limit / receive minimum settings with random gaps on
// both channels and one long output hold-off. The checker does the compare.
// ----------------------------------------------------------------------------
module tb;
	import ppcl_pkg::*;

	logic        clk;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [0:0]  cfg_index = '0;
	logic [15:0] cfg_wdata = '0;
	logic        in_valid = 1'b0;
	logic        out_stall = 1'b0;
	item_t       cur = '0;

	logic        in_stall;
	logic        out_valid;
	logic [7:0]  data_pins;
	logic        strobe_level;
	logic        led_level;
	logic        ready_res;
	logic        done_res;
	logic [7:0]  rx_byte;
	logic        rx_valid;
	logic        checksum_error;
	logic        timeout_flag;

	int          errors;
	int          due_count;
	logic        idle_on = 1'b1;
	logic        squeeze_req = 1'b0;
	logic [7:0]  rx_min_now = RX_MIN_RST;

	parallel_port_copier_link DUT (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
		.in_valid(in_valid), .in_stall(in_stall),
		.req_valid(cur.req_valid), .req_type(cur.req_type), .cmd_code(cur.cmd_code),
		.address(cur.address), .length(cur.length), .data_byte(cur.data_byte),
		.status_pins(cur.status_pins),
		.out_valid(out_valid), .out_stall(out_stall),
		.data_pins(data_pins), .strobe_level(strobe_level), .led_level(led_level),
		.ready_res(ready_res), .done_res(done_res), .rx_byte(rx_byte),
		.rx_valid(rx_valid), .checksum_error(checksum_error), .timeout_flag(timeout_flag)
	);

	ppcl_checker u_checker (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
		.in_valid(in_valid), .in_stall(in_stall),
		.req_valid(cur.req_valid), .req_type(cur.req_type), .cmd_code(cur.cmd_code),
		.address(cur.address), .length(cur.length), .data_byte(cur.data_byte),
		.status_pins(cur.status_pins),
		.out_valid(out_valid), .out_stall(out_stall),
		.data_pins(data_pins), .strobe_level(strobe_level), .led_level(led_level),
		.ready_res(ready_res), .done_res(done_res), .rx_byte(rx_byte),
		.rx_valid(rx_valid), .checksum_error(checksum_error), .timeout_flag(timeout_flag),
		.errors(errors), .due_count(due_count)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Hard stop
	initial begin
		#1_000_000;
		$display("tb: errors");
		$finish;
	end

	// Result side: random stall bursts, plus one long hold-off on request
	initial begin
		wait (arst_n);
		forever begin
			@(posedge clk);
			if (squeeze_req) begin
				squeeze_req = 1'b0;
				out_stall <= 1'b1;
				repeat (120) @(posedge clk);
				out_stall <= 1'b0;
			end else if (idle_on && $urandom_range(0, 9) == 0) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 13)) @(posedge clk);
				out_stall <= 1'b0;
			end
		end
	end

	function automatic item_t mk(input logic v, input logic [2:0] k, input logic [7:0] code,
			input logic [15:0] addr, input logic [15:0] len, input logic [7:0] dat,
			input logic [7:0] st);
		item_t t;
		t.req_valid   = v;
		t.req_type    = k;
		t.cmd_code    = code;
		t.address     = addr;
		t.length      = len;
		t.data_byte   = dat;
		t.status_pins = st;
		return t;
	endfunction

	// Filler tick: random request fields, dropped while the link is busy
	function automatic item_t junk(input logic [7:0] st);
		return mk(1'($urandom_range(0, 1)), 3'($urandom), 8'($urandom), 16'($urandom),
			16'($urandom), 8'($urandom), st);
	endfunction

	// Offer one tick, with an optional gap first; return after its transfer
	task automatic drive_tick(input item_t t);
		if (idle_on && $urandom_range(0, 9) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 13)) @(posedge clk);
		end
		in_valid <= 1'b1;
		cur <= t;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
	endtask

	// Send request with busy asserted on every poll; n ticks cover it exactly
	task automatic send_req(input logic [2:0] k, input logic [7:0] code,
			input logic [15:0] addr, input logic [15:0] len, input logic [7:0] dat,
			input int n);
		drive_tick(mk(1'b1, k, code, addr, len, dat, {1'b0, 7'($urandom)}));
		repeat (n - 1)
			drive_tick(junk({1'b0, 7'($urandom)}));
	endtask

	// Receive request: low nibble held for the first wait, high for the second
	task automatic recv_req(input logic [2:0] k, input logic [3:0] lo, input logic [3:0] hi);
		int m;
		m = (rx_min_now == 8'd0) ? 1 : int'(rx_min_now);
		drive_tick(mk(1'b1, k, 8'($urandom), 16'($urandom), 16'($urandom), 8'($urandom),
			{1'b1, lo, 3'($urandom)}));
		repeat (m - 1)
			drive_tick(junk({1'b1, lo, 3'($urandom)}));
		repeat (m)
			drive_tick(junk({1'b1, hi, 3'($urandom)}));
	endtask

	// Drain, then write both registers while the link is quiet
	task automatic reconfigure(input logic [15:0] lim, input logic [7:0] minp);
		in_valid <= 1'b0;
		@(posedge clk);
		while (due_count != 0)
			@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= CFG_POLL_LIMIT;
		cfg_wdata <= lim;
		@(posedge clk);
		cfg_index <= CFG_RX_MIN;
		cfg_wdata <= {8'd0, minp};
		@(posedge clk);
		cfg_we <= 1'b0;
		rx_min_now = minp;
	endtask

	// Random ticks; busy level wanders so waits pass, stall and time out
	task automatic random_ticks(input int n);
		logic       lvl;
		int         r;
		logic [2:0] k;
		lvl = 1'b0;
		repeat (n) begin
			if ($urandom_range(0, 2) == 0)
				lvl = ~lvl;
			r = $urandom_range(0, 15);
			if (r < 4)
				k = REQ_FRAME;
			else if (r < 7)
				k = REQ_DATA;
			else if (r < 9)
				k = REQ_SUM;
			else if (r < 12)
				k = REQ_RX;
			else if (r < 14)
				k = REQ_RX_CHK;
			else if (r < 15)
				k = REQ_CLR;
			else
				k = 3'($urandom_range(6, 7));
			drive_tick(mk($urandom_range(0, 3) == 0, k, 8'($urandom), 16'($urandom),
				16'($urandom), 8'($urandom), {lvl, 7'($urandom)}));
		end
	endtask

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset settings: frames with extreme fields, data, checksum send
		send_req(REQ_FRAME, 8'hFF, 16'hFFFF, 16'h0000, 8'h00, 18);
		send_req(REQ_FRAME, 8'h00, 16'h0000, 16'hFFFF, 8'hFF, 18);
		send_req(REQ_DATA, 8'h00, 16'h0000, 16'h0000, 8'h00, 2);
		send_req(REQ_DATA, 8'hFF, 16'hFFFF, 16'hFFFF, 8'hFF, 2);
		send_req(REQ_SUM, 8'h5A, 16'h1234, 16'h4321, 8'h3C, 2);
		recv_req(REQ_RX, 4'h5, 4'hA);
		// frame reseeds the sum, so a received 0x81 matches, 0xFF does not
		send_req(REQ_FRAME, 8'h42, 16'h8001, 16'h0180, 8'h00, 18);
		recv_req(REQ_RX_CHK, 4'h1, 4'h8);
		recv_req(REQ_RX_CHK, 4'hF, 4'hF);
		// undefined request kinds and a clear with no timeout pending
		drive_tick(mk(1'b1, 3'd6, 8'hFF, 16'hFFFF, 16'hFFFF, 8'hFF, 8'hFF));
		drive_tick(mk(1'b1, 3'd7, 8'h00, 16'h0000, 16'h0000, 8'h00, 8'h07));
		drive_tick(mk(1'b1, REQ_CLR, 8'h00, 16'h0000, 16'h0000, 8'h00, 8'h80));

		// Zero poll limit: wrong busy level times out on the first poll
		reconfigure(16'd0, 8'd0);
		drive_tick(mk(1'b1, REQ_DATA, 8'h00, 16'h0000, 16'h0000, 8'hA5, 8'h80));
		drive_tick(mk(1'b1, REQ_FRAME, 8'h11, 16'h2233, 16'h4455, 8'h00, 8'h80));
		drive_tick(mk(1'b1, REQ_RX_CHK, 8'h00, 16'h0000, 16'h0000, 8'h00, 8'h00));
		drive_tick(mk(1'b1, REQ_RX, 8'h00, 16'h0000, 16'h0000, 8'h00, 8'h7F));
		drive_tick(mk(1'b1, REQ_CLR, 8'h00, 16'h0000, 16'h0000, 8'h00, 8'h00));
		recv_req(REQ_RX, 4'hC, 4'h3);
		random_ticks(150);

		// Hold off the result side while ticks keep coming
		reconfigure(16'd1, 8'd0);
		squeeze_req = 1'b1;
		random_ticks(220);

		reconfigure(16'd2, 8'd1);
		random_ticks(200);

		reconfigure(16'hFFFF, 8'hFF);
		random_ticks(260);

		reconfigure(16'd5, 8'd3);
		random_ticks(200);

		reconfigure(POLL_LIMIT_RST, RX_MIN_RST);
		random_ticks(200);

		// Closing stretch with no gaps on either side
		idle_on = 1'b0;
		reconfigure(16'd3, 8'd2);
		random_ticks(200);

		in_valid <= 1'b0;
		@(posedge clk);
		while (due_count != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (errors == 0 && due_count == 0)
			$display("tb: clean");
		else
			$display("tb: errors");
		$finish;
	end

endmodule
